// ----- rtl/bvh_pkg.sv -----
// Shared constants and types for the box overlap query block.
package bvh_pkg;
	localparam int unsigned NodeCount    = 127;
	localparam int unsigned NodeAw       = 7;
	localparam int unsigned FieldBits    = 32;
	localparam int unsigned DefMaxLeaves = 64;
	localparam int unsigned DefStackDep  = 32;
	localparam int unsigned DefCoordBits = 32;
	localparam int unsigned VisitLimit   = 127;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_BOX  = 3'd1;
	localparam logic [2:0] ST_NO_TREE  = 3'd2;
	localparam logic [2:0] ST_TOO_MANY = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] CFG_ROOT     = 2'd0;
	localparam logic [1:0] CFG_PRESENT  = 2'd1;
	localparam logic [1:0] CFG_CAPACITY = 2'd2;

	typedef struct packed {
		logic       op;
		logic [6:0] node_index;
		logic       is_leaf;
		logic [6:0] child_a;
		logic [6:0] child_b;
		logic [FieldBits-1:0] lo_x;
		logic [FieldBits-1:0] lo_y;
		logic [FieldBits-1:0] lo_z;
		logic [FieldBits-1:0] hi_x;
		logic [FieldBits-1:0] hi_y;
		logic [FieldBits-1:0] hi_z;
	} bvh_in_t;

	typedef struct packed {
		logic [2:0] status;
		logic       hit_valid;
		logic [5:0] leaf_id;
		logic       last;
	} bvh_out_t;

	// Compare unit request from sequencer to comparator.
	typedef struct packed {
		logic [FieldBits-1:0] a;
		logic [FieldBits-1:0] b;
	} bvh_cmp_req_t;
endpackage

// ----- rtl/bvh_if.sv -----
// Valid/ready channel interface carrying one payload type.
interface bvh_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/bvh_cmp.sv -----
// Shared signed greater-than unit on coordinates truncated to COORD_BITS bits (at most 32).
module bvh_cmp #(
	parameter int unsigned COORD_BITS = bvh_pkg::DefCoordBits
) (
	input  bvh_pkg::bvh_cmp_req_t req,
	output logic                  gt
);
	import bvh_pkg::*;
	localparam int unsigned W = (COORD_BITS < FieldBits) ? COORD_BITS : FieldBits;
	logic signed [W-1:0] a_w, b_w;
	assign a_w = req.a[W-1:0];
	assign b_w = req.b[W-1:0];
	assign gt  = a_w > b_w;
endmodule

// ----- rtl/bvh_box_overlap_query.sv -----
// Box overlap query over a stored bounding-volume tree: a sequencer around one shared comparator.
// Write items (op 0) store one node and produce no result. A query (op 1) runs a sequencer
// that owns one signed comparator. After the accept, the sequencer checks the query box for
// min > max on each axis. Every visited node is then read from node memory and compared
// (max > qlo and qhi > min per axis), stopping early on the first miss. An overlapping node
// then passes through a decision state. Descending into child B goes straight back to the
// read; a leaf or a miss goes to a pop state and, when a pending node remains, to a
// stack-read state before the next read. Node 127 is never compared and counts as a miss.
// After the traversal the 64-bit hit map is scanned one leaf id per cycle and each set bit
// is sent as one result; the scan holds while a result waits. At most 127 visits are
// allowed, and errors end the query early. The input is not ready while a query runs or a
// result waits. The node memory is not cleared at reset; reading an unwritten node is
// undefined.
module bvh_box_overlap_query #(
	parameter int unsigned MAX_LEAVES  = bvh_pkg::DefMaxLeaves,
	parameter int unsigned STACK_DEPTH = bvh_pkg::DefStackDep,
	parameter int unsigned COORD_BITS  = bvh_pkg::DefCoordBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	bvh_if.sink         in_ch,
	bvh_if.source       out_ch
);
	import bvh_pkg::*;

	localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned SaW = $clog2(STACK_DEPTH);
	localparam int unsigned LW  = $clog2(MAX_LEAVES);

	localparam logic [3:0] S_IDLE = 4'd0, S_BOX = 4'd1, S_READ = 4'd2, S_CMP = 4'd3,
		S_NODE = 4'd4, S_POP = 4'd5, S_SCAN = 4'd6, S_OUT = 4'd7, S_POPRD = 4'd8;

	logic [3:0] state_q;
	logic [6:0] root_q, cap_q;
	logic       present_q;

	// node memory
	logic [FieldBits-1:0] mem_min_x [NodeCount], mem_min_y [NodeCount], mem_min_z [NodeCount];
	logic [FieldBits-1:0] mem_max_x [NodeCount], mem_max_y [NodeCount], mem_max_z [NodeCount];
	logic [14:0]          mem_links [NodeCount];
	logic [6:0]           stack_mem [STACK_DEPTH];

	logic [FieldBits-1:0] n_min_q [3], n_max_q [3], q_lo_q [3], q_hi_q [3];
	logic [14:0] links_q;
	logic [6:0]  cur_q, pop_q, hits_q, visits_q;
	logic [SpW-1:0] sp_q;
	logic [2:0]  step_q;
	logic [63:0] map_q;
	logic [LW:0] scan_q;
	logic [5:0]  seen_q;
	bvh_out_t    res_q;
	logic        out_v_q;

	bvh_cmp_req_t req;
	logic gt;
	bvh_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (.req(req), .gt(gt));

	// Route compare operands by step.
	always_comb begin
		req = '0;
		case (state_q)
			S_BOX: begin
				req.a = q_lo_q[step_q[1:0]];
				req.b = q_hi_q[step_q[1:0]];
			end
			S_CMP: begin
				if (!step_q[0]) begin
					req.a = n_max_q[step_q[2:1]];
					req.b = q_lo_q[step_q[2:1]];
				end else begin
					req.a = q_hi_q[step_q[2:1]];
					req.b = n_min_q[step_q[2:1]];
				end
			end
			default: req = '0;
		endcase
	end

	assign in_ch.ready = (state_q == S_IDLE) && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = res_q;

	logic in_acc;
	assign in_acc = in_ch.valid && in_ch.ready;

	// Node and stack memories.
	logic       push_en;
	logic [6:0] leaf_a;
	logic       leaf_ok;
	assign leaf_a  = links_q[13:7];
	assign leaf_ok = (leaf_a < 7'(MAX_LEAVES)) && (leaf_a < 7'd64);
	assign push_en = (state_q == S_NODE) && !links_q[14] && (sp_q < SpW'(STACK_DEPTH));

	always_ff @(posedge clk) begin
		if (in_acc && in_ch.data.op == OP_WRITE && in_ch.data.node_index != 7'd127) begin
			mem_min_x[in_ch.data.node_index] <= in_ch.data.lo_x;
			mem_min_y[in_ch.data.node_index] <= in_ch.data.lo_y;
			mem_min_z[in_ch.data.node_index] <= in_ch.data.lo_z;
			mem_max_x[in_ch.data.node_index] <= in_ch.data.hi_x;
			mem_max_y[in_ch.data.node_index] <= in_ch.data.hi_y;
			mem_max_z[in_ch.data.node_index] <= in_ch.data.hi_z;
			mem_links[in_ch.data.node_index] <= {in_ch.data.is_leaf, in_ch.data.child_a,
				in_ch.data.child_b};
		end
		if (state_q == S_READ && cur_q != 7'd127) begin
			n_min_q[0] <= mem_min_x[cur_q];
			n_min_q[1] <= mem_min_y[cur_q];
			n_min_q[2] <= mem_min_z[cur_q];
			n_max_q[0] <= mem_max_x[cur_q];
			n_max_q[1] <= mem_max_y[cur_q];
			n_max_q[2] <= mem_max_z[cur_q];
			links_q    <= mem_links[cur_q];
		end
		if (push_en)
			stack_mem[sp_q[SaW-1:0]] <= leaf_a;
		if (state_q == S_POP)
			pop_q <= stack_mem[SaW'(sp_q - SpW'(1))];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			root_q    <= '0;
			present_q <= 1'b0;
			cap_q     <= 7'd64;
			out_v_q   <= 1'b0;
			map_q     <= '0;
			res_q     <= '0;
			step_q    <= '0;
			sp_q      <= '0;
			hits_q    <= '0;
			visits_q  <= '0;
			cur_q     <= '0;
			scan_q    <= '0;
			seen_q    <= '0;
			q_lo_q    <= '{default: '0};
			q_hi_q    <= '{default: '0};
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROOT:     root_q    <= cfg_data;
					CFG_PRESENT:  present_q <= cfg_data[0];
					CFG_CAPACITY: cap_q     <= cfg_data;
					default: ;
				endcase
			end
			// the scan state owns the result valid while it runs
			if (out_v_q && out_ch.ready && state_q != S_SCAN)
				out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_ch.data.op == OP_QUERY) begin
						q_lo_q <= '{in_ch.data.lo_x, in_ch.data.lo_y, in_ch.data.lo_z};
						q_hi_q <= '{in_ch.data.hi_x, in_ch.data.hi_y, in_ch.data.hi_z};
						map_q    <= '0;
						hits_q   <= '0;
						sp_q     <= '0;
						visits_q <= '0;
						step_q   <= '0;
						cur_q    <= root_q;
						if (!present_q) begin
							res_q   <= '{ST_NO_TREE, 1'b0, 6'd0, 1'b1};
							out_v_q <= 1'b1;
						end else
							state_q <= S_BOX;
					end
				end
				S_BOX: begin
					if (gt) begin
						res_q   <= '{ST_BAD_BOX, 1'b0, 6'd0, 1'b1};
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (step_q == 3'd2) begin
						step_q  <= '0;
						state_q <= S_READ;
					end else
						step_q <= step_q + 3'd1;
				end
				S_READ: begin
					// visit counting; node 127 overlaps nothing
					if (visits_q == 7'(VisitLimit)) begin
						res_q   <= '{ST_OVERFLOW, 1'b0, 6'd0, 1'b1};
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						visits_q <= visits_q + 7'd1;
						step_q   <= '0;
						state_q  <= (cur_q == 7'd127) ? S_POP : S_CMP;
					end
				end
				S_CMP: begin
					if (!gt)
						state_q <= S_POP;
					else if (step_q == 3'd5)
						state_q <= S_NODE;
					else
						step_q <= step_q + 3'd1;
				end
				S_NODE: begin
					if (links_q[14]) begin
						if (leaf_ok && !map_q[leaf_a[5:0]]) begin
							if (hits_q >= cap_q) begin
								res_q   <= '{ST_TOO_MANY, 1'b0, 6'd0, 1'b1};
								out_v_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								map_q[leaf_a[5:0]] <= 1'b1;
								hits_q  <= hits_q + 7'd1;
								state_q <= S_POP;
							end
						end else
							state_q <= S_POP;
					end else if (sp_q >= SpW'(STACK_DEPTH)) begin
						res_q   <= '{ST_OVERFLOW, 1'b0, 6'd0, 1'b1};
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						sp_q    <= sp_q + SpW'(1);
						cur_q   <= links_q[6:0];
						state_q <= S_READ;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						scan_q  <= '0;
						seen_q  <= '0;
						if (hits_q == '0) begin
							res_q   <= '{ST_OK, 1'b0, 6'd0, 1'b1};
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end else
							state_q <= S_SCAN;
					end else begin
						sp_q    <= sp_q - SpW'(1);
						state_q <= S_POPRD;
					end
				end
				S_POPRD: begin
					cur_q   <= pop_q;
					state_q <= S_READ;
				end
				S_SCAN: begin
					// one leaf id per cycle while no result waits; send each set bit, drop the valid otherwise
					if (!out_v_q || out_ch.ready) begin
						if (scan_q == (LW+1)'(MAX_LEAVES)) begin
							out_v_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							if (map_q[6'(scan_q)]) begin
								res_q   <= '{ST_OK, 1'b1, 6'(scan_q),
									(7'(seen_q) + 7'd1 == hits_q)};
								out_v_q <= 1'b1;
								seen_q  <= seen_q + 6'd1;
							end else
								out_v_q <= 1'b0;
							scan_q <= scan_q + (LW+1)'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/bvh_checker.sv -----
// Port-level checker for the box overlap query block, bound to the top level.
module bvh_checker (
	input logic     clk,
	input logic     arst_n,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input bvh_pkg::bvh_out_t out_data
);
	import bvh_pkg::*;
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.last && !out_data.hit_valid)
		else $error("error result not single");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit_valid |-> out_data.last)
		else $error("empty result not last");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while a result waits");
endmodule

bind bvh_box_overlap_query bvh_checker u_bvh_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
